>>> rtl/uvf_pkg.sv
// Shared types and constants for the unique value filter.
package uvf_pkg;

    localparam int VALUE_W = 32;
    localparam int CNT_W   = 2;

    localparam logic [CNT_W-1:0] CNT_ONE = 2'd1;
    localparam logic [CNT_W-1:0] CNT_MAX = 2'd2;

    // One table slot: stored key and its saturating occurrence count.
    typedef struct packed {
        logic [VALUE_W-1:0] key;
        logic [CNT_W-1:0]   cnt;
    } entry_t;

    // Status bits carried on the result tuser.
    typedef struct packed {
        logic overflow;
        logic none_found;
    } res_user_t;

endpackage

>>> rtl/unique_value_filter.sv
// Unique value filter: emits the values seen exactly once in a set, in order of first appearance.
// A request is searched against the occupied slots (at most TABLE_DEPTH), one slot per cycle;
//   a hit ends the search early, and no new request is taken until the search is done.
// After a request with tlast the table is scanned slot by slot (read, then check), then the
//   final result is sent; the scan waits while the output is stalled.
// Reset (aresetn low, synchronous) empties the table via the fill count; no clearing pass.
module unique_value_filter #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value
    input  logic        s_tlast,   // last_in
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] unique_value
    output logic        m_tlast,   // last_out
    output logic [1:0]  m_tuser    // [0] none_found, [1] overflow
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int FW = $clog2(TABLE_DEPTH + 1);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SEARCH = 3'd1;
    localparam logic [2:0] ST_RD     = 3'd2;
    localparam logic [2:0] ST_CHK    = 3'd3;
    localparam logic [2:0] ST_FLUSH  = 3'd4;

    uvf_pkg::entry_t mem [TABLE_DEPTH];
    uvf_pkg::entry_t rd_q;
    logic            rd_en;
    logic [AW-1:0]   rd_addr;
    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    uvf_pkg::entry_t wr_data;

    logic [2:0]                  state_reg, state_next;
    logic [AW-1:0]               idx_reg, idx_next;
    logic [FW-1:0]               fill_reg, fill_next;
    logic                        ovf_reg, ovf_next;
    logic [uvf_pkg::VALUE_W-1:0] val_reg, val_next;
    logic                        last_reg, last_next;
    logic [uvf_pkg::VALUE_W-1:0] pend_reg, pend_next;
    logic                        pend_vld_reg, pend_vld_next;

    logic                        out_vld_reg, out_vld_next;
    logic [uvf_pkg::VALUE_W-1:0] out_data_reg, out_data_next;
    logic                        out_last_reg, out_last_next;
    uvf_pkg::res_user_t          out_user_reg, out_user_next;

    logic [FW-1:0] idx_p1;
    logic          hit;
    logic          out_free;

    // Table memory: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_q <= mem[rd_addr];
        end
    end

    assign idx_p1   = FW'(idx_reg) + FW'(1);
    assign hit      = (FW'(idx_reg) < fill_reg) && (rd_q.key == val_reg);
    assign out_free = !out_vld_reg || m_tready;

    always_comb begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        fill_next     = fill_reg;
        ovf_next      = ovf_reg;
        val_next      = val_reg;
        last_next     = last_reg;
        pend_next     = pend_reg;
        pend_vld_next = pend_vld_reg;
        out_vld_next  = out_vld_reg && !m_tready;
        out_data_next = out_data_reg;
        out_last_next = out_last_reg;
        out_user_next = out_user_reg;
        rd_en         = 1'b0;
        rd_addr       = idx_reg;
        wr_en         = 1'b0;
        wr_addr       = idx_reg;
        wr_data       = '{key: val_reg, cnt: uvf_pkg::CNT_ONE};

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    val_next   = s_tdata;
                    last_next  = s_tlast;
                    idx_next   = '0;
                    rd_en      = 1'b1;
                    rd_addr    = '0;
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (hit) begin
                    wr_en   = 1'b1;
                    wr_data = '{key: val_reg,
                                cnt: (rd_q.cnt == uvf_pkg::CNT_ONE) ? uvf_pkg::CNT_MAX
                                                                    : rd_q.cnt};
                end else if (idx_p1 < fill_reg) begin
                    rd_en    = 1'b1;
                    rd_addr  = AW'(idx_p1);
                    idx_next = AW'(idx_p1);
                end else if (fill_reg < FW'(TABLE_DEPTH)) begin
                    wr_en     = 1'b1;
                    wr_addr   = AW'(fill_reg);
                    fill_next = fill_reg + FW'(1);
                end else begin
                    ovf_next = 1'b1;
                end
                if (hit || !(idx_p1 < fill_reg)) begin
                    idx_next   = '0;
                    state_next = last_reg ? ST_RD : ST_IDLE;
                end
            end
            ST_RD: begin
                rd_en      = 1'b1;
                rd_addr    = idx_reg;
                state_next = ST_CHK;
            end
            ST_CHK: begin
                // Hold the newest unique value back so the final one can carry tlast.
                if (!(rd_q.cnt == uvf_pkg::CNT_ONE && pend_vld_reg && !out_free)) begin
                    if (rd_q.cnt == uvf_pkg::CNT_ONE) begin
                        if (pend_vld_reg) begin
                            out_vld_next  = 1'b1;
                            out_data_next = pend_reg;
                            out_last_next = 1'b0;
                            out_user_next = '{overflow: ovf_reg, none_found: 1'b0};
                        end
                        pend_next     = rd_q.key;
                        pend_vld_next = 1'b1;
                    end
                    if (idx_p1 < fill_reg) begin
                        idx_next   = AW'(idx_p1);
                        state_next = ST_RD;
                    end else begin
                        state_next = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH: begin
                if (out_free) begin
                    out_vld_next  = 1'b1;
                    out_data_next = pend_vld_reg ? pend_reg : '0;
                    out_last_next = 1'b1;
                    out_user_next = '{overflow: ovf_reg, none_found: !pend_vld_reg};
                    pend_vld_next = 1'b0;
                    fill_next     = '0;
                    ovf_next      = 1'b0;
                    idx_next      = '0;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            idx_reg      <= '0;
            fill_reg     <= '0;
            ovf_reg      <= 1'b0;
            pend_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            fill_reg     <= fill_next;
            ovf_reg      <= ovf_next;
            pend_vld_reg <= pend_vld_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        val_reg      <= val_next;
        last_reg     <= last_next;
        pend_reg     <= pend_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
        out_user_reg <= out_user_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_user_reg;

endmodule

>>> rtl/uvf_checker.sv
// Port-level checker for the unique value filter, bound to the top level.
module uvf_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tlast,
    input logic [1:0]  m_tuser
);

    // A stalled result keeps its payload.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
                                  && $stable(m_tuser))
        else $error("stalled result changed");

    // The empty-set marker is a lone, zero, final result.
    a_none_found: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tlast && (m_tdata == 32'd0))
        else $error("none_found result malformed");

    // No request is accepted in the cycle after an accepted one.
    a_busy_after_req: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted on back-to-back cycles");

    // Reset drops any pending result.
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind unique_value_filter uvf_checker u_uvf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);
